@@ design/tdg_pkg.sv @@
// Shared types and constants for the TD-error and advantage estimation block.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
package tdg_pkg;

    // Field widths fixed by the data formats.
    localparam int VAL_W     = 16;   // Q8.8 reward and critic value
    localparam int RES_W     = 24;   // Q16.8 results
    localparam int CFG_W     = 17;   // Q1.16 coefficients
    localparam int IDX_OUT_W = 6;    // step index field
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] DISCOUNT_RST = 17'd65208;
    localparam logic [CFG_W-1:0] LAMBDA_RST   = 17'd62259;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_DISCOUNT = 1'b0;
    localparam logic REG_LAMBDA   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_FINAL,
        S_GL,
        S_BK_RD,
        S_BK_WR,
        S_EM_RD,
        S_EM_LD
    } t_state;

    typedef struct packed {
        logic capture;    // latch the input item, start gamma*V
        logic load_wr;    // write delta of the previous step
        logic load_adv;   // advance the step counter after a non-final item
        logic fin_start;  // write the final delta, start gamma*lambda
        logic gl_round;   // round gamma*lambda
        logic bk_rd;      // backward pass: read delta, multiply
        logic bk_wr;      // backward pass: add, saturate, write advantage
        logic em_rd;      // emit: read both stores
        logic em_ld;      // emit: load the output register
    } t_cmd;

    typedef struct packed {
        logic fin_now;    // current item ends the trajectory
        logic idx_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

@@ design/tdg_if.sv @@
// Valid/ready channel interfaces for input steps and result items.
// Depends on tdg_pkg for the field widths.
interface tdg_step_if;
    import tdg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] reward;
    logic signed [VAL_W-1:0] critic_value;
    logic                    final_step;

    modport source (output valid, reward, critic_value, final_step, input ready);
    modport sink   (input valid, reward, critic_value, final_step, output ready);
endinterface

interface tdg_result_if;
    import tdg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] td_error;
    logic signed [RES_W-1:0] advantage;
    logic [IDX_OUT_W-1:0]    step_index;
    logic                    last_result;

    modport source (output valid, td_error, advantage, step_index, last_result, input ready);
    modport sink   (input valid, td_error, advantage, step_index, last_result, output ready);
endinterface

@@ design/tdg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ design/tdg_ctrl.sv @@
// Controller state machine: sequences loading, the backward advantage pass
// and the forward emit. Depends on tdg_pkg.
module tdg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tdg_pkg::t_status i_status,
    output tdg_pkg::t_cmd    o_cmd
);
    import tdg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = i_status.fin_now ? S_FINAL : S_IDLE;
            end
            S_FINAL:  n_state = S_GL;
            S_GL:     n_state = S_BK_RD;
            S_BK_RD:  n_state = S_BK_WR;
            S_BK_WR: begin
                n_state = i_status.idx_zero ? S_EM_RD : S_BK_RD;
            end
            S_EM_RD:  n_state = S_EM_LD;
            S_EM_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? S_IDLE : S_EM_RD;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.load_wr  = !i_status.idx_zero;
                o_cmd.load_adv = !i_status.fin_now;
            end
            S_FINAL:  o_cmd.fin_start = 1'b1;
            S_GL:     o_cmd.gl_round  = 1'b1;
            S_BK_RD:  o_cmd.bk_rd     = 1'b1;
            S_BK_WR:  o_cmd.bk_wr     = 1'b1;
            S_EM_RD:  o_cmd.em_rd     = 1'b1;
            S_EM_LD:  o_cmd.em_ld     = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

@@ design/tdg_dp.sv @@
// Datapath: input holding registers, multipliers, rounding and saturation,
// the delta and advantage stores and the output register.
// Depends on tdg_pkg and tdg_ram.
module tdg_dp #(
    parameter int TRAJ_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdg_pkg::t_cmd                       i_cmd,
    output tdg_pkg::t_status                    o_status,
    input  logic [tdg_pkg::CFG_W-1:0]           i_discount,
    input  logic [tdg_pkg::CFG_W-1:0]           i_lambda,
    input  logic signed [tdg_pkg::VAL_W-1:0]    i_reward,
    input  logic signed [tdg_pkg::VAL_W-1:0]    i_critic_value,
    input  logic                                i_final_step,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [tdg_pkg::RES_W-1:0]    o_td_error,
    output logic signed [tdg_pkg::RES_W-1:0]    o_advantage,
    output logic [tdg_pkg::IDX_OUT_W-1:0]       o_step_index,
    output logic                                o_last_result
);
    import tdg_pkg::*;

    localparam int IW = $clog2(TRAJ_LEN);
    localparam logic [IW-1:0] LAST_IDX = IW'(TRAJ_LEN - 1);
    localparam logic signed [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

    logic signed [VAL_W-1:0] r_cur_r;
    logic signed [VAL_W-1:0] r_cur_v;
    logic signed [VAL_W-1:0] r_held_r;
    logic signed [VAL_W-1:0] r_held_v;
    logic                    r_cur_fin;
    logic [IW-1:0]           r_idx;
    logic [IW-1:0]           r_last;
    logic signed [33:0]      r_prod;
    logic [33:0]             r_gl_prod;
    logic [17:0]             r_gl;
    logic signed [42:0]      r_mprod;
    logic signed [RES_W-1:0] r_next;

    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_out_td;
    logic signed [RES_W-1:0] r_out_adv;
    logic [IDX_OUT_W-1:0]    r_out_idx;
    logic                    r_out_last;

    logic signed [33:0]      prod_rnd;
    logic signed [17:0]      gv;
    logic signed [19:0]      delta_prev;
    logic signed [16:0]      delta_fin;
    logic [33:0]             gl_sum;
    logic signed [42:0]      mprod_rnd;
    logic signed [26:0]      adv_term;
    logic signed [27:0]      adv_sum;
    logic signed [RES_W-1:0] adv_sat;

    logic                    dl_wr_en;
    logic [IW-1:0]           dl_wr_addr;
    logic [RES_W-1:0]        dl_wr_data;
    logic [RES_W-1:0]        dl_rd_data;
    logic [RES_W-1:0]        adv_rd_data;

    // Round half up by 2^16: add half an LSB, keep the upper bits.
    assign prod_rnd   = r_prod + 34'sd32768;
    assign gv         = prod_rnd[33:16];
    assign delta_prev = 20'(r_held_r) + 20'(gv) - 20'(r_held_v);
    assign delta_fin  = 17'(r_cur_r) - 17'(r_cur_v);
    assign gl_sum     = r_gl_prod + 34'd32768;
    assign mprod_rnd  = r_mprod + 43'sd32768;
    assign adv_term   = mprod_rnd[42:16];
    assign adv_sum    = 28'($signed(dl_rd_data)) + 28'(adv_term);

    always_comb begin
        if (adv_sum > 28'(SAT_MAX)) begin
            adv_sat = SAT_MAX;
        end else if (adv_sum < 28'(SAT_MIN)) begin
            adv_sat = SAT_MIN;
        end else begin
            adv_sat = adv_sum[RES_W-1:0];
        end
    end

    assign dl_wr_en   = i_cmd.load_wr | i_cmd.fin_start;
    assign dl_wr_addr = i_cmd.fin_start ? r_idx : r_idx - IW'(1);
    assign dl_wr_data = i_cmd.fin_start ? RES_W'(delta_fin) : RES_W'(delta_prev);

    tdg_ram #(.WIDTH(RES_W), .DEPTH(TRAJ_LEN)) u_delta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dl_wr_en),
        .i_wr_addr (dl_wr_addr),
        .i_wr_data (dl_wr_data),
        .i_rd_en   (i_cmd.bk_rd | i_cmd.em_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (dl_rd_data)
    );

    tdg_ram #(.WIDTH(RES_W), .DEPTH(TRAJ_LEN)) u_adv_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.bk_wr),
        .i_wr_addr (r_idx),
        .i_wr_data (adv_sat),
        .i_rd_en   (i_cmd.em_rd),
        .i_rd_addr (r_idx),
        .o_rd_data (adv_rd_data)
    );

    // Control state and held step values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_r     <= '0;
            r_cur_v     <= '0;
            r_held_r    <= '0;
            r_held_v    <= '0;
            r_cur_fin   <= 1'b0;
            r_idx       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_held_r  <= r_cur_r;
                r_held_v  <= r_cur_v;
                r_cur_r   <= i_reward;
                r_cur_v   <= i_critic_value;
                r_cur_fin <= i_final_step;
            end
            if (i_cmd.fin_start) begin
                r_last <= r_idx;
            end
            if (i_cmd.load_adv) begin
                r_idx <= r_idx + IW'(1);
            end else if (i_cmd.bk_wr && r_idx != '0) begin
                r_idx <= r_idx - IW'(1);
            end else if (i_cmd.em_ld) begin
                r_idx <= (r_idx == r_last) ? '0 : r_idx + IW'(1);
            end
            if (i_cmd.em_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_prod <= $signed({1'b0, i_discount}) * i_critic_value;
        end
        if (i_cmd.fin_start) begin
            r_gl_prod <= i_discount * i_lambda;
            r_next    <= '0;
        end
        if (i_cmd.gl_round) begin
            r_gl <= gl_sum[33:16];
        end
        if (i_cmd.bk_rd) begin
            r_mprod <= $signed({1'b0, r_gl}) * r_next;
        end
        if (i_cmd.bk_wr) begin
            r_next <= adv_sat;
        end
        if (i_cmd.em_ld) begin
            r_out_td   <= dl_rd_data;
            r_out_adv  <= adv_rd_data;
            r_out_idx  <= IDX_OUT_W'(r_idx);
            r_out_last <= (r_idx == r_last);
        end
    end

    // The step at the last store index ends the trajectory even without the mark.
    assign o_status.fin_now  = r_cur_fin | (r_idx == LAST_IDX);
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.idx_last = (r_idx == r_last);
    assign o_status.out_free = !r_out_valid | i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_td_error    = r_out_td;
    assign o_advantage   = r_out_adv;
    assign o_step_index  = r_out_idx;
    assign o_last_result = r_out_last;
endmodule

@@ design/td_error_and_gae.sv @@
// Load: each input item is captured and gamma*V multiplied, then the delta of the step
// before is written. After the final item: final delta write and gamma*lambda multiply,
// gamma*lambda rounding, the backward advantage recursion per step (delta read and
// multiply, then add and store), then one result at a time while the consumer is ready.
// Reset (i_rst_n low, synchronous) clears control state and restores the coefficient
// registers; the delta and advantage stores are not cleared.
module td_error_and_gae #(
    parameter int TRAJ_LEN = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tdg_step_if.sink                     i_step,
    tdg_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdg_pkg::APB_AW-1:0]   paddr,
    input  logic [tdg_pkg::APB_DW-1:0]   pwdata,
    output logic [tdg_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import tdg_pkg::*;

    logic [CFG_W-1:0] r_discount;
    logic [CFG_W-1:0] r_lambda;
    logic             cfg_wr;
    t_cmd             cmd;
    t_status          status;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount <= DISCOUNT_RST;
            r_lambda   <= LAMBDA_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DISCOUNT: r_discount <= pwdata[CFG_W-1:0];
                REG_LAMBDA:   r_lambda   <= pwdata[CFG_W-1:0];
                default: begin
                    r_discount <= r_discount;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DISCOUNT: prdata = APB_DW'(r_discount);
            REG_LAMBDA:   prdata = APB_DW'(r_lambda);
            default:      prdata = '0;
        endcase
    end

    tdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_step.valid),
        .o_in_ready (i_step.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tdg_dp #(.TRAJ_LEN(TRAJ_LEN)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_discount     (r_discount),
        .i_lambda       (r_lambda),
        .i_reward       (i_step.reward),
        .i_critic_value (i_step.critic_value),
        .i_final_step   (i_step.final_step),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_td_error     (o_result.td_error),
        .o_advantage    (o_result.advantage),
        .o_step_index   (o_result.step_index),
        .o_last_result  (o_result.last_result)
    );
endmodule

@@ sim/td_error_and_gae_chk.sv @@
// Checker for td_error_and_gae: watches the step, result and register channels,
// predicts TD errors and advantages per trajectory and compares every result item.
// Depends on tdg_pkg and the channel interfaces in tdg_if.sv.
`timescale 1ns / 100ps

module td_error_and_gae_chk #(
    parameter int TRAJ_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tdg_step_if                        step,
    tdg_result_if                      result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tdg_pkg::APB_AW-1:0] paddr,
    input  logic [tdg_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_saturated
);
    import tdg_pkg::*;

    localparam longint RES_MAX = (longint'(1) <<< (RES_W - 1)) - 1;
    localparam longint RES_MIN = -(longint'(1) <<< (RES_W - 1));

    typedef struct {
        logic signed [RES_W-1:0] td_error;
        logic signed [RES_W-1:0] advantage;
        logic [IDX_OUT_W-1:0]    step_index;
        logic                    last_result;
    } t_step_result;

    t_step_result     results_due[$];
    logic [CFG_W-1:0] gamma_q;
    logic [CFG_W-1:0] lambda_q;
    longint           held_reward;
    longint           held_value;
    int               steps_held;
    longint           delta_mem[TRAJ_LEN];
    longint           adv_mem[TRAJ_LEN];

    // Round a product with 16 fraction bits to the nearest, halves going up.
    function automatic longint round_q16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint clip_res(input longint x);
        if (x > RES_MAX)
            return RES_MAX;
        if (x < RES_MIN)
            return RES_MIN;
        return x;
    endfunction

    task automatic flag(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        o_errors++;
    endtask

    // Folds one step into the trajectory; on its last step runs the advantage
    // recursion backward and queues one result per step in forward order.
    task automatic absorb_step(input longint r, input longint v, input logic fin);
        int           n;
        int           len;
        logic         ends;
        longint       gl;
        longint       carry;
        t_step_result res;
        n    = steps_held;
        ends = fin;
        if (n >= TRAJ_LEN)
            n = TRAJ_LEN - 1;
        // A trajectory that reaches the store depth ends there, marked or not.
        if (n == TRAJ_LEN - 1)
            ends = 1'b1;
        if (n > 0)
            delta_mem[n-1] = clip_res(held_reward + round_q16(longint'(gamma_q) * v)
                                      - held_value);
        held_reward = r;
        held_value  = v;
        if (!ends) begin
            steps_held = n + 1;
            return;
        end
        delta_mem[n] = clip_res(r - v);
        len   = n + 1;
        gl    = round_q16(longint'(gamma_q) * longint'(lambda_q));
        carry = 0;
        for (int i = len - 1; i >= 0; i--) begin
            carry      = clip_res(delta_mem[i] + round_q16(gl * carry));
            adv_mem[i] = carry;
        end
        for (int i = 0; i < len; i++) begin
            res.td_error    = RES_W'(delta_mem[i]);
            res.advantage   = RES_W'(adv_mem[i]);
            res.step_index  = IDX_OUT_W'(i);
            res.last_result = (i == len - 1);
            results_due.push_back(res);
        end
        steps_held = 0;
    endtask

    task automatic check_result();
        t_step_result want;
        if (results_due.size() == 0) begin
            flag($sformatf("result item with nothing expected (step %0d)",
                           result.step_index));
            return;
        end
        want = results_due.pop_front();
        if (result.td_error !== want.td_error)
            flag($sformatf("td_error at step %0d: expected %0d, got %0d",
                           want.step_index, want.td_error, result.td_error));
        if (result.advantage !== want.advantage)
            flag($sformatf("advantage at step %0d: expected %0d, got %0d",
                           want.step_index, want.advantage, result.advantage));
        if (result.step_index !== want.step_index)
            flag($sformatf("step_index: expected %0d, got %0d",
                           want.step_index, result.step_index));
        if (result.last_result !== want.last_result)
            flag($sformatf("last_result at step %0d: expected %0d, got %0d",
                           want.step_index, want.last_result, result.last_result));
        o_checked++;
        if (longint'(want.advantage) == RES_MAX || longint'(want.advantage) == RES_MIN)
            o_saturated++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gamma_q     = DISCOUNT_RST;
            lambda_q    = LAMBDA_RST;
            held_reward = 0;
            held_value  = 0;
            steps_held  = 0;
            o_errors    = 0;
            o_checked   = 0;
            o_saturated = 0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_DISCOUNT)
                    gamma_q = pwdata[CFG_W-1:0];
                else
                    lambda_q = pwdata[CFG_W-1:0];
            end
            if (result.valid && result.ready)
                check_result();
            if (step.valid && step.ready)
                absorb_step(step.reward, step.critic_value, step.final_step);
        end
        o_pending = results_due.size();
    end

endmodule

@@ sim/td_error_and_gae_tb.sv @@
// Top of the td_error_and_gae testbench: clock, reset, step stimulus in bursts,
// result back-pressure, coefficient writes and the verdict.
// Depends on tdg_pkg, tdg_if.sv, the block and td_error_and_gae_chk.
`timescale 1ns / 100ps

module td_error_and_gae_tb;
    import tdg_pkg::*;

    localparam int TRAJ_LEN    = 64;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 150;
    localparam int PHASE_ITEMS = 7;
    localparam int N_PHASES    = 8;

    localparam logic [CFG_W-1:0] COEF_ZERO = '0;
    localparam logic [CFG_W-1:0] COEF_ONE  = 17'd65536;
    localparam logic [CFG_W-1:0] COEF_TOP  = 17'h1FFFF;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_COIN,
        RDY_SPARSE
    } t_ready_mode;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int          errors;
    int          pending;
    int          checked;
    int          saturated;
    int          items_sent   = 0;
    int          traj_count   = 0;
    int          phase_count  = 0;
    int          burst_left   = 0;
    int          quiet_cycles = 0;
    int          ready_tick   = 0;
    t_ready_mode ready_mode   = RDY_ALWAYS;
    logic [15:0] ready_pat    = 16'hFFFF;

    tdg_step_if   step_ch();
    tdg_result_if res_ch();

    always #2 i_clk = ~i_clk;

    td_error_and_gae #(
        .TRAJ_LEN (TRAJ_LEN)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    td_error_and_gae_chk #(
        .TRAJ_LEN (TRAJ_LEN)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .step        (step_ch),
        .result      (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_saturated (saturated)
    );

    // The result side periodically picks a new stall behavior and pattern at random.
    always @(posedge i_clk) begin
        ready_tick++;
        if (ready_tick % 80 == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_pat  = 16'($urandom);
        end
        case (ready_mode)
            RDY_ALWAYS:  res_ch.ready <= 1'b1;
            RDY_PATTERN: res_ch.ready <= ready_pat[ready_tick % 16];
            RDY_COIN:    res_ch.ready <= ($urandom_range(0, 2) != 0);
            default:     res_ch.ready <= ((ready_tick % 24) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (step_ch.valid && step_ch.ready) || (res_ch.valid && res_ch.ready)
                || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, pending);
                $display("** td_error_and_gae: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_q88();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one step item; a new burst starts after a random gap, often none.
    task automatic push_step(input logic signed [VAL_W-1:0] r,
                             input logic signed [VAL_W-1:0] v,
                             input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                step_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        step_ch.valid        <= 1'b1;
        step_ch.reward       <= r;
        step_ch.critic_value <= v;
        step_ch.final_step   <= fin;
        do @(posedge i_clk); while (!step_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic run_traj(input int len, input logic marked);
        for (int i = 0; i < len; i++)
            push_step(pick_q88(), pick_q88(), marked && (i == len - 1));
        traj_count++;
    endtask

    // Holds the step side until every queued result has come out.
    task automatic drain();
        step_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] gam;
        logic [CFG_W-1:0] lam;
        int               start;
        int               len;
        step_ch.valid        <= 1'b0;
        step_ch.reward       <= '0;
        step_ch.critic_value <= '0;
        step_ch.final_step   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset coefficients: single-step trajectories at both extremes and
        // at zero, then a four-step one of extreme values and a two-step one of small values.
        push_step(16'sh7FFF, 16'sh8000, 1'b1);
        push_step(16'sh8000, 16'sh7FFF, 1'b1);
        push_step('0, '0, 1'b1);
        push_step(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_step(16'sh8000, 16'sh8000, 1'b0);
        push_step(16'sh7FFF, 16'sh8000, 1'b0);
        push_step(16'sh8000, 16'sh7FFF, 1'b1);
        push_step(16'sh0100, 16'shFF00, 1'b0);
        push_step(16'shFFFF, 16'sh0001, 1'b1);
        traj_count += 5;
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin gam = COEF_ONE;  lam = COEF_ONE;  end
                1:       begin gam = COEF_ZERO; lam = COEF_ZERO; end
                2:       begin gam = COEF_TOP;  lam = COEF_TOP;  end
                3:       begin gam = COEF_ZERO; lam = COEF_ONE;  end
                4:       begin gam = COEF_ONE;  lam = COEF_ZERO; end
                5:       begin
                    gam = 17'($urandom_range(0, 131071));
                    lam = 17'($urandom_range(0, 131071));
                end
                6:       begin gam = COEF_TOP;  lam = 17'($urandom_range(0, 65536)); end
                default: begin gam = DISCOUNT_RST; lam = LAMBDA_RST; end
            endcase
            apb_write(REG_DISCOUNT, gam);
            apb_write(REG_LAMBDA, lam);
            phase_count++;
            // A full-depth trajectory that is never marked final, and a half-depth
            // one marked on its last step.
            if (p == 2)
                run_traj(TRAJ_LEN, 1'b0);
            if (p == 0)
                run_traj(TRAJ_LEN / 2, 1'b1);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                run_traj(len, 1'b1);
            end
            drain();
        end

        repeat (TAIL) @(posedge i_clk);
        $display("Sent %0d step items in %0d trajectories under %0d coefficient settings,",
                 items_sent, traj_count, phase_count + 1);
        $display("checked %0d results, %0d of them with a saturated advantage.",
                 checked, saturated);
        if (errors == 0 && pending == 0) begin
            $display("** td_error_and_gae: PASSED **");
        end else begin
            $display("** td_error_and_gae: FAILED **");
        end
        $finish;
    end

endmodule

@@ td_error_and_gae.f @@
design/tdg_pkg.sv
design/tdg_if.sv
design/tdg_ram.sv
design/tdg_ctrl.sv
design/tdg_dp.sv
design/td_error_and_gae.sv
sim/td_error_and_gae_chk.sv
sim/td_error_and_gae_tb.sv
